// ===== sv/ipd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipd_pkg
// Character codes, matcher steps and the shared header-prefix step function
// for the +IPD payload deframer.
// ----------------------------------------------------------------------------
package ipd_pkg;

   // framing characters
   localparam logic [7:0] CharColon = 8'h3A;  // ':'
   localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
   localparam logic [7:0] CharI     = 8'h49;  // 'I'
   localparam logic [7:0] CharP     = 8'h50;  // 'P'
   localparam logic [7:0] CharD     = 8'h44;  // 'D'
   localparam logic [7:0] CharComma = 8'h2C;  // ','
   localparam logic [7:0] CharZero  = 8'h30;  // '0'
   localparam logic [7:0] CharNine  = 8'h39;  // '9'

   // matcher progress
   localparam logic [2:0] StepIdle  = 3'd0;
   localparam logic [2:0] StepPlus  = 3'd1;
   localparam logic [2:0] StepI     = 3'd2;
   localparam logic [2:0] StepP     = 3'd3;
   localparam logic [2:0] StepD     = 3'd4;
   localparam logic [2:0] StepComma = 3'd5;  // id matcher only
   localparam logic [2:0] StepId    = 3'd6;  // id matcher only

   typedef struct packed {
      logic       hit;
      logic [2:0] step;
   } prefix_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

   // advance through "+IPD"; a '+' right after '+' holds step one
   function automatic prefix_type prefix_next(input logic [7:0] c, input logic [2:0] s);
      prefix_type r;
      r.hit  = 1'b1;
      r.step = StepIdle;
      if (c == CharPlus && s == StepIdle) begin
         r.step = StepPlus;
      end else if (c == CharI && s == StepPlus) begin
         r.step = StepI;
      end else if (c == CharP && s == StepI) begin
         r.step = StepP;
      end else if (c == CharD && s == StepP) begin
         r.step = StepD;
      end else begin
         r.hit  = 1'b0;
         r.step = (c == CharPlus && s == StepPlus) ? StepPlus : StepIdle;
      end
      return r;
   endfunction

endpackage

// ===== sv/ipd_payload_deframer.sv =====
// ----------------------------------------------------------------------------
// ipd_payload_deframer
// Strips "+IPD,len:" and "+IPD,id,len:" headers from a modem byte stream and
// marks the payload bytes that follow.
// ----------------------------------------------------------------------------
// Result: registered; an accepted word's result word is valid in the next cycle.
// Throughput: one word per cycle unless rsp_tready stalls; all parsing is a
//    single pass of shallow logic from the byte into the state and result register.
// Reset: synchronous, active high; clears both matchers, the length parser,
//    the payload counter, the reported length and id, and the result valid.
// ----------------------------------------------------------------------------
module ipd_payload_deframer
   import ipd_pkg::*;
#(
   parameter int LENGTH_WINDOW = 5   // length window: LENGTH_WINDOW + 1 characters, then one is skipped; 1..7
) (
   input  logic        clock,
   input  logic        reset,
   // received byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // deframed stream, one word per received byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] payload_byte, [23:8] frame_length,
                                     // [31:24] link_id
   output logic [0:0]  rsp_tuser     // [0] payload_valid
);

   // the count may run one past the window before it wraps back to zero
   localparam int CountWidth = $clog2(LENGTH_WINDOW + 2);
   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(LENGTH_WINDOW);

   // ---- parser state ----
   logic [2:0]            plain_step_ff, plain_step_in;
   logic [2:0]            id_step_ff,    id_step_in;
   logic [15:0]           remain_ff,     remain_in;
   logic                  armed_ff,      armed_in;
   logic                  active_ff,     active_in;
   logic [CountWidth-1:0] count_ff,      count_in;
   logic [15:0]           last_len_ff,   last_len_in;
   logic [7:0]            last_id_ff,    last_id_in;

   // ---- result register ----
   logic        rsp_valid_ff;
   logic        out_flag_ff,  out_flag_in;
   logic [7:0]  out_byte_ff,  out_byte_in;

   logic       accept;
   logic [7:0] c;
   prefix_type plain_pre, id_pre;

   // take a word whenever the result slot is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;

   assign plain_pre = prefix_next(c, plain_step_ff);
   assign id_pre    = prefix_next(c, id_step_ff);

   always_comb begin
      remain_in   = remain_ff;
      armed_in    = armed_ff;
      active_in   = active_ff;
      count_in    = count_ff;
      last_len_in = last_len_ff;
      last_id_in  = last_id_ff;
      out_flag_in = 1'b0;

      // payload countdown; the byte after the last one is dropped
      if (active_ff) begin
         if (remain_ff != 16'd0) begin
            remain_in   = remain_ff - 16'd1;
            out_flag_in = 1'b1;
         end else begin
            active_in = 1'b0;
            remain_in = 16'd0;
            armed_in  = 1'b0;
         end
      end

      // decimal length field; past the window one byte is skipped
      if (armed_in) begin
         if (count_in <= CountLimit) begin
            count_in = count_in + CountWidth'(1);
            if (c == CharColon) begin
               armed_in  = 1'b0;
               count_in  = '0;
               active_in = 1'b1;
            end else if (is_digit(c)) begin
               // x10 as shifts, wraps at 16 bits
               remain_in   = (remain_in << 3) + (remain_in << 1) + {8'd0, c - CharZero};
               last_len_in = remain_in;
            end
         end else begin
            count_in = '0;
         end
      end

      // "+IPD," matcher
      plain_step_in = plain_pre.step;
      if (!plain_pre.hit && c == CharComma && plain_step_ff == StepD) begin
         plain_step_in = StepIdle;
         armed_in      = 1'b1;
         count_in      = '0;
         remain_in     = 16'd0;
      end

      // "+IPD,d," matcher
      id_step_in = id_pre.step;
      if (!id_pre.hit) begin
         if (c == CharComma && id_step_ff == StepD) begin
            id_step_in = StepComma;
         end else if (is_digit(c) && id_step_ff == StepComma) begin
            id_step_in = StepId;
            last_id_in = c;
         end else if (c == CharComma && id_step_ff == StepId) begin
            id_step_in = StepIdle;
            armed_in   = 1'b1;
            count_in   = '0;
            remain_in  = 16'd0;
         end
      end

      out_byte_in = out_flag_in ? c : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plain_step_ff <= StepIdle;
         id_step_ff    <= StepIdle;
         remain_ff     <= 16'd0;
         armed_ff      <= 1'b0;
         active_ff     <= 1'b0;
         count_ff      <= '0;
         last_len_ff   <= 16'd0;
         last_id_ff    <= 8'd0;
      end else if (accept) begin
         plain_step_ff <= plain_step_in;
         id_step_ff    <= id_step_in;
         remain_ff     <= remain_in;
         armed_ff      <= armed_in;
         active_ff     <= active_in;
         count_ff      <= count_in;
         last_len_ff   <= last_len_in;
         last_id_ff    <= last_id_in;
      end
   end

   // result slot: filled on accept, emptied when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_flag_ff <= out_flag_in;
         out_byte_ff <= out_byte_in;
      end
   end

   // length and id of the result are the values left after its byte
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {last_id_ff, last_len_ff, out_byte_ff};
   assign rsp_tuser  = out_flag_ff;

endmodule

// ===== tb/tb_ipd_payload_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipd_payload_deframer
// Self-checking bench for the +IPD payload deframer. The block gets a short
// directed byte table and then a random stream of headers, length fields,
// payloads and noise. Every result word is checked against a behavioral
// deframer kept in this bench or a typed-in word. Random gaps and stalls are
// applied on both sides.
// ----------------------------------------------------------------------------
module tb_ipd_payload_deframer
   import ipd_pkg::*;
();

   localparam int LengthWindow = 5;
   localparam int DirectedRows = 26;
   localparam int RandomItems  = 1450;

   // one result word, fields from the msb down
   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [15:0] frame_length;
      logic [7:0]  link_id;
   } deframed_type;

   // one planned input byte; when checked_by_hand is set, the typed-in word
   // replaces the deframer's own prediction
   typedef struct packed {
      logic [7:0]   rx;
      logic         checked_by_hand;
      deframed_type want;
   } stim_type;

   localparam logic [33:0] Untyped = '0;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [7:0] payload_byte, [23:8] frame_length, [31:24] link_id
   logic [0:0]  rsp_tuser;    // [0] payload_valid

   ipd_payload_deframer #(
      .LENGTH_WINDOW(LengthWindow)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // --------------------------------------------------------------------------
   // Directed table. Walks through: reset values with the byte extremes, a
   // doubled '+' ahead of the header, a five-digit length that wraps, a
   // non-digit inside the length, a seventh length character dropped by the
   // window, a header arriving mid-payload (ends it one byte later), an id
   // header, and a zero-length payload whose only effect is the swallowed byte.
   // The first length digit also completes the id matcher, so the id reads '9'.
   // --------------------------------------------------------------------------
   stim_type directed_table [DirectedRows] = '{
      {8'h00,     1'b1, 1'b0, 8'h00, 16'd0, 8'h00},      // idle after reset
      {8'hFF,     1'b1, 1'b0, 8'h00, 16'd0, 8'h00},
      {CharPlus,  Untyped},
      {CharPlus,  Untyped},                              // '+' at step one holds
      {CharI,     Untyped},
      {CharP,     Untyped},
      {CharD,     Untyped},
      {CharComma, Untyped},                              // plain header armed
      {CharNine,  Untyped},
      {CharNine,  Untyped},
      {CharNine,  Untyped},
      {CharNine,  Untyped},
      {CharNine,  Untyped},                              // 99999 wraps to 34463
      {8'h78,     Untyped},                              // 'x' only counts
      {8'h32,     Untyped},                              // past the window: dropped
      {CharColon, Untyped},
      {8'hFF,     1'b1, 1'b1, 8'hFF, 16'd34463, 8'h39},  // first payload byte
      {CharPlus,  Untyped},                              // header inside payload
      {CharI,     Untyped},
      {CharP,     Untyped},
      {CharD,     Untyped},
      {CharComma, Untyped},                              // re-arm clears the count
      {8'h34,     Untyped},                              // swallowed, id digit '4'
      {CharComma, Untyped},                              // id header armed
      {CharColon, Untyped},                              // zero-length payload
      {8'h00,     Untyped}                               // swallowed
   };

   // header cut short at a random point for the noise part
   logic [7:0] broken_header [7] = '{CharPlus, CharI, CharP, CharD, CharComma, 8'h37,
                                     CharComma};

   stim_type     byte_plan [$];
   deframed_type expected_words [$];
   int           mismatches = 0;
   int           words_sent = 0;

   // deframer state kept by the bench
   logic [2:0]  plain_step   = StepIdle;
   logic [2:0]  id_step      = StepIdle;
   logic [15:0] count_left   = '0;
   logic        len_armed    = 1'b0;
   logic        in_payload   = 1'b0;
   logic [2:0]  len_chars    = '0;
   logic [15:0] shown_length = '0;
   logic [7:0]  shown_id     = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generous cap, well above the slowest legal run
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 40)
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic push_rx(input logic [7:0] b);
      byte_plan.push_back({b, 1'b0, 33'd0});
   endtask

   // decimal text of v, most significant digit first
   task automatic push_number(input int v);
      string digits;
      digits = $sformatf("%0d", v);
      for (int k = 0; k < digits.len(); k++) push_rx(digits[k]);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   // one step along "+IPD"; a '+' while at step one stays at step one
   function automatic logic [2:0] header_step(input logic [7:0] c, input logic [2:0] s);
      logic [7:0] wanted;
      case (s)
         StepIdle: wanted = CharPlus;
         StepPlus: wanted = CharI;
         StepI:    wanted = CharP;
         default:  wanted = CharD;
      endcase
      if (s <= StepP && c == wanted) return s + 3'd1;
      return (c == CharPlus && s == StepPlus) ? StepPlus : StepIdle;
   endfunction

   // advances the bench state by one received byte, returns the result word
   function automatic deframed_type deframe_byte(input logic [7:0] c);
      deframed_type w;
      logic [2:0]   nxt;
      logic         is_num;
      is_num = (c >= CharZero) && (c <= CharNine);
      w = '0;

      // payload countdown; the byte after the last one is swallowed
      if (in_payload) begin
         if (count_left != 0) begin
            count_left--;
            w.payload_valid = 1'b1;
            w.payload_byte  = c;
         end else begin
            in_payload = 1'b0;
            len_armed  = 1'b0;
         end
      end

      // length field: at most LengthWindow + 1 characters, then one dropped
      if (len_armed) begin
         if (len_chars <= LengthWindow) begin
            len_chars++;
            if (c == CharColon) begin
               len_armed  = 1'b0;
               len_chars  = '0;
               in_payload = 1'b1;
            end else if (is_num) begin
               count_left   = count_left * 16'd10 + {8'd0, c - CharZero};
               shown_length = count_left;
            end
         end else begin
            len_chars = '0;
         end
      end

      // "+IPD,"
      nxt = header_step(c, plain_step);
      if (c == CharComma && plain_step == StepD) begin
         nxt        = StepIdle;
         len_armed  = 1'b1;
         len_chars  = '0;
         count_left = '0;
      end
      plain_step = nxt;

      // "+IPD,d,"
      nxt = header_step(c, id_step);
      if (c == CharComma && id_step == StepD) begin
         nxt = StepComma;
      end else if (is_num && id_step == StepComma) begin
         nxt      = StepId;
         shown_id = c;
      end else if (c == CharComma && id_step == StepId) begin
         nxt        = StepIdle;
         len_armed  = 1'b1;
         len_chars  = '0;
         count_left = '0;
      end
      id_step = nxt;

      w.frame_length = shown_length;
      w.link_id      = shown_id;
      return w;
   endfunction

   // --------------------------------------------------------------------------
   // Sender: plan, reset, then one word per planned byte with random gaps
   // --------------------------------------------------------------------------
   initial begin : sender
      int           n;
      int           lk;
      int           len;
      int           gap;
      int           wait_cycles;
      deframed_type want;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;

      foreach (directed_table[k]) byte_plan.push_back(directed_table[k]);

      // mostly well-formed frames with random content, the rest noise
      while (byte_plan.size() < DirectedRows + RandomItems) begin
         if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 3) == 0) push_rx(CharPlus);
            push_rx(CharPlus);
            push_rx(CharI);
            push_rx(CharP);
            push_rx(CharD);
            push_rx(CharComma);
            if ($urandom_range(0, 1)) begin
               push_rx(8'(CharZero + $urandom_range(0, 9)));
               push_rx(CharComma);
            end
            lk  = $urandom_range(0, 99);
            len = $urandom_range(0, 24);
            if (lk < 70) begin
               push_number(len);
            end else if (lk < 78) begin
               push_rx(CharZero);                      // leading zero
               push_number(len);
            end else if (lk < 86) begin
               push_number($urandom_range(10000, 99999));   // may wrap past 16 bits
            end else if (lk < 93) begin
               push_number($urandom_range(0, 9));
               push_rx(8'($urandom_range(8'h3B, 8'hFF)));  // junk inside the length
               push_number($urandom_range(0, 9));
            end else begin
               push_number($urandom_range(100000, 9999999)); // overruns the window
            end
            push_rx(CharColon);
            // long lengths get cut short by the next header
            n = (lk < 78) ? len : $urandom_range(0, 30);
            repeat (n) push_rx(8'($urandom_range(0, 255)));
            push_rx(8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 1)) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) push_rx(broken_header[k]);
            push_rx(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) push_rx(8'($urandom_range(0, 255)));
         end
      end

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < byte_plan.size(); i++) begin
         gap = ((i / 150) % 4 == 2) ? 0 : pick_gap();   // some gap-free stretches
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= byte_plan[i].rx;
         do @(posedge clock); while (!req_tready);
         want = deframe_byte(byte_plan[i].rx);
         if (byte_plan[i].checked_by_hand) want = byte_plan[i].want;
         expected_words.push_back(want);
         words_sent++;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;

      // drain, then keep watching for anything stray
      wait_cycles = 0;
      while (expected_words.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch("words never delivered", expected_words.size(), 0);

      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // --------------------------------------------------------------------------
   // Receiver: random stalls, quiet stretches, and one long hold-off so the
   // output fills and req_tready drops while words keep being offered
   // --------------------------------------------------------------------------
   initial begin : receiver
      int stall_left;
      int hold_left;
      bit hold_done;
      int cycle_no;

      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      cycle_no   = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cycle_no++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && words_sent >= 400) begin
            hold_done = 1'b1;
            hold_left = 299;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ((cycle_no / 300) % 3 == 1) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Checker: each delivered word against the oldest prediction
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : response_check
      deframed_type got;
      deframed_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.payload_valid = rsp_tuser[0];
         got.payload_byte  = rsp_tdata[7:0];
         got.frame_length  = rsp_tdata[23:8];
         got.link_id       = rsp_tdata[31:24];
         if (expected_words.size() == 0) begin
            report_mismatch("word with nothing expected", int'(rsp_tdata), 0);
         end else begin
            want = expected_words.pop_front();
            if (got.payload_valid !== want.payload_valid)
               report_mismatch("payload_valid", int'(got.payload_valid),
                               int'(want.payload_valid));
            if (got.payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", int'(got.payload_byte),
                               int'(want.payload_byte));
            if (got.frame_length !== want.frame_length)
               report_mismatch("frame_length", int'(got.frame_length),
                               int'(want.frame_length));
            if (got.link_id !== want.link_id)
               report_mismatch("link_id", int'(got.link_id), int'(want.link_id));
         end
      end
   end

endmodule
